@@ design/bba_pkg.sv @@
// Shared constants and types for the buddy block allocator.
`default_nettype none
package bba_pkg;
   localparam int unsigned ADDR_BITS_DEF    = 20;
   localparam int unsigned HEADER_BYTES_DEF = 32;

   localparam int unsigned OP_W     = 2;
   localparam int unsigned REQ_W    = 21;
   localparam int unsigned STATUS_W = 3;
   localparam int unsigned GRANT_W  = 20;
   localparam int unsigned COUNT_W  = 16;
   localparam int unsigned ORD_W    = 5;
   localparam int unsigned META_W   = 7;

   localparam logic [ORD_W-1:0] POOL_ORDER_RESET = 5'd20;

   typedef enum logic [OP_W-1:0] {
      OP_ALLOC  = 2'd0,
      OP_FREE   = 2'd1,
      OP_FINISH = 2'd2,
      OP_INIT   = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_NOT_INIT = 3'd1,
      ST_NO_SPACE = 3'd2,
      ST_BAD_ADDR = 3'd3,
      ST_ALREADY  = 3'd4
   } status_type;

   // Block table entry: head flag, used flag, order.
   typedef struct packed {
      logic             head;
      logic             used;
      logic [ORD_W-1:0] ord;
   } meta_type;
endpackage
`default_nettype wire

@@ design/bba_if.sv @@
// Request, response and register-write channel interfaces.
`default_nettype none
interface bba_req_if;
   logic                        valid;
   logic                        ready;
   logic [bba_pkg::OP_W-1:0]    op;
   logic [bba_pkg::REQ_W-1:0]   request_bytes;
   logic [bba_pkg::REQ_W-1:0]   user_offset;
   modport source (output valid, op, request_bytes, user_offset, input ready);
   modport sink (input valid, op, request_bytes, user_offset, output ready);
endinterface

interface bba_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bba_pkg::STATUS_W-1:0]  status;
   logic [bba_pkg::GRANT_W-1:0]   granted_offset;
   logic [bba_pkg::COUNT_W-1:0]   pending_count;
   modport source (output valid, status, granted_offset, pending_count, input ready);
   modport sink (input valid, status, granted_offset, pending_count, output ready);
endinterface

interface bba_csr_if;
   logic                       valid;
   logic                       ready;
   logic [bba_pkg::ORD_W-1:0]  pool_order;
   modport source (output valid, pool_order, input ready);
   modport sink (input valid, pool_order, output ready);
endinterface
`default_nettype wire

@@ design/buddy_block_allocator.sv @@
// Top level of the buddy block allocator: sequencer, block table and channels.
`default_nettype none
// Binary buddy allocator over a pool of 2^pool_order bytes (capped at
// ADDR_BITS), one block table entry per minimum unit of 2^clog2(HEADER_BYTES)
// bytes, held in a single-port-read RAM of 2^(ADDR_BITS-3) entries. After
// reset and after every finish request the table is cleared one entry per
// cycle, during which no request is taken; register writes are taken at all
// times. One request is worked on at a time, and the registered table RAM
// read sets the pace. Initialise, finish and any request refused before the
// table is read go straight to the response; free reads the block entry, then
// reads each buddy in turn and merges while it is a free head of the same
// order, up to the whole pool; allocate first steps the block order k up from
// the minimum order, walks the blocks from the pool base, then splits the best
// fit once per level; k exceeding the pool is refused without a walk.
// A finished response waits in an output register while the next request is
// taken.
module buddy_block_allocator #(
   parameter int unsigned ADDR_BITS    = bba_pkg::ADDR_BITS_DEF,
   parameter int unsigned HEADER_BYTES = bba_pkg::HEADER_BYTES_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   bba_req_if.sink    req_if,
   bba_rsp_if.source  rsp_if,
   bba_csr_if.sink    csr_if
);
   import bba_pkg::*;

   localparam int unsigned MIN_ORD = $clog2(HEADER_BYTES);
   localparam int unsigned SLOT_W  = ADDR_BITS - 3;
   localparam int unsigned DEPTH   = 1 << SLOT_W;
   localparam int unsigned OFF_W   = (ADDR_BITS + 2 > REQ_W + 1) ? ADDR_BITS + 2 : REQ_W + 1;
   localparam int unsigned NEED_W  = REQ_W + 1;

   typedef enum logic [3:0] {
      S_CLR, S_IDLE, S_CEIL, S_ARD, S_ACHK, S_ADONE, S_SPLIT,
      S_FRD, S_FCHK, S_FLOOP, S_FBCHK, S_FEND, S_EMIT
   } state_type;

   state_type            state_ff, state_in;
   logic [ORD_W-1:0]     csr_ord_ff;
   logic                 ready_ff, ready_in;
   logic [ORD_W-1:0]     p_ff, p_in;
   logic [COUNT_W-1:0]   live_ff, live_in;
   logic [OFF_W-1:0]     off_ff, off_in;
   logic [OFF_W-1:0]     best_ff, best_in;
   logic [ORD_W-1:0]     best_ord_ff, best_ord_in;
   logic                 found_ff, found_in;
   logic [ORD_W-1:0]     k_ff, k_in;
   logic [ORD_W-1:0]     j_ff, j_in;
   logic [ORD_W-1:0]     o_ff, o_in;
   logic [NEED_W-1:0]    need_ff, need_in;
   logic [SLOT_W-1:0]    clr_ff, clr_in;
   logic                 clr_after_ff, clr_after_in;
   status_type           res_st_ff, res_st_in;
   logic [GRANT_W-1:0]   res_off_ff, res_off_in;
   logic [COUNT_W-1:0]   res_cnt_ff, res_cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_st_ff, rsp_st_in;
   logic [GRANT_W-1:0]   rsp_off_ff, rsp_off_in;
   logic [COUNT_W-1:0]   rsp_cnt_ff, rsp_cnt_in;

   logic                 wr_en;
   logic [SLOT_W-1:0]    wr_addr, rd_addr;
   meta_type             wr_meta, rd_meta;
   logic [META_W-1:0]    rd_word;

   logic                 req_fire;
   logic [OFF_W-1:0]     pool_size, user_ext, user_off, bud, step;
   logic [ORD_W-1:0]     init_p, jm;

   assign rd_meta = meta_type'(rd_word);

   bba_ram #(.WIDTH(META_W), .DEPTH(DEPTH)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (META_W'(wr_meta)),
      .rd_addr (rd_addr),
      .rd_data (rd_word)
   );

   assign req_if.ready      = (state_ff == S_IDLE);
   assign req_fire          = req_if.valid && req_if.ready;
   assign csr_if.ready      = 1'b1;
   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.status     = rsp_st_ff;
   assign rsp_if.granted_offset = rsp_off_ff;
   assign rsp_if.pending_count  = rsp_cnt_ff;

   assign pool_size = OFF_W'(1) << p_ff;
   assign user_ext  = OFF_W'(req_if.user_offset);
   assign user_off  = user_ext - OFF_W'(HEADER_BYTES);
   assign step      = OFF_W'(1) << o_ff;
   assign bud       = off_ff ^ step;
   assign init_p    = (csr_ord_ff > ORD_W'(ADDR_BITS)) ? ORD_W'(ADDR_BITS) : csr_ord_ff;
   assign jm        = j_ff - 1'b1;

   always_comb begin
      state_in     = state_ff;
      ready_in     = ready_ff;
      p_in         = p_ff;
      live_in      = live_ff;
      off_in       = off_ff;
      best_in      = best_ff;
      best_ord_in  = best_ord_ff;
      found_in     = found_ff;
      k_in         = k_ff;
      j_in         = j_ff;
      o_in         = o_ff;
      need_in      = need_ff;
      clr_in       = clr_ff;
      clr_after_in = clr_after_ff;
      res_st_in    = res_st_ff;
      res_off_in   = res_off_ff;
      res_cnt_in   = res_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_st_in    = rsp_st_ff;
      rsp_off_in   = rsp_off_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      wr_en        = 1'b0;
      wr_addr      = SLOT_W'(off_ff >> MIN_ORD);
      wr_meta      = '0;
      rd_addr      = SLOT_W'(off_ff >> MIN_ORD);

      case (state_ff)
         S_CLR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == SLOT_W'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               res_st_in    = ST_OK;
               res_off_in   = '0;
               res_cnt_in   = '0;
               clr_after_in = 1'b0;
               state_in     = S_EMIT;
               case (op_type'(req_if.op))
                  OP_ALLOC: begin
                     if (!ready_ff) begin
                        res_st_in = ST_NOT_INIT;
                     end else begin
                        need_in  = NEED_W'(req_if.request_bytes) + NEED_W'(HEADER_BYTES);
                        k_in     = ORD_W'(MIN_ORD);
                        state_in = S_CEIL;
                     end
                  end
                  OP_FREE: begin
                     if (!ready_ff) begin
                        res_st_in = ST_NOT_INIT;
                     end else if (user_ext < OFF_W'(HEADER_BYTES) || user_off >= pool_size
                                  || user_off[MIN_ORD-1:0] != '0) begin
                        res_st_in = ST_BAD_ADDR;
                     end else begin
                        off_in   = user_off;
                        state_in = S_FRD;
                     end
                  end
                  OP_FINISH: begin
                     res_cnt_in   = live_ff;
                     live_in      = '0;
                     ready_in     = 1'b0;
                     p_in         = '0;
                     clr_after_in = 1'b1;
                  end
                  default: begin
                     if (ready_ff) begin
                        res_st_in = ST_ALREADY;
                     end else if ((OFF_W'(1) << init_p) <= OFF_W'(HEADER_BYTES)) begin
                        res_st_in = ST_NO_SPACE;
                     end else begin
                        // table is already clear whenever the pool is down
                        wr_en    = 1'b1;
                        wr_addr  = '0;
                        wr_meta  = '{head: 1'b1, used: 1'b0, ord: init_p};
                        p_in     = init_p;
                        live_in  = '0;
                        ready_in = 1'b1;
                     end
                  end
               endcase
            end
         end
         S_CEIL: begin
            if (((NEED_W + 1)'(1) << k_ff) < (NEED_W + 1)'(need_ff)) begin
               k_in = k_ff + 1'b1;
            end else if (k_ff > p_ff) begin
               res_st_in = ST_NO_SPACE;
               state_in  = S_EMIT;
            end else begin
               off_in   = '0;
               found_in = 1'b0;
               state_in = S_ARD;
            end
         end
         S_ARD: begin
            state_in = (off_ff >= pool_size) ? S_ADONE : S_ACHK;
         end
         S_ACHK: begin
            if (!rd_meta.head || rd_meta.ord < ORD_W'(MIN_ORD) || rd_meta.ord > p_ff) begin
               state_in = S_ADONE;
            end else begin
               if (!rd_meta.used && rd_meta.ord >= k_ff
                   && (!found_ff || rd_meta.ord < best_ord_ff)) begin
                  found_in    = 1'b1;
                  best_ord_in = rd_meta.ord;
                  best_in     = off_ff;
               end
               off_in   = off_ff + (OFF_W'(1) << rd_meta.ord);
               state_in = S_ARD;
            end
         end
         S_ADONE: begin
            if (!found_ff) begin
               res_st_in = ST_NO_SPACE;
               state_in  = S_EMIT;
            end else begin
               j_in     = best_ord_ff;
               state_in = S_SPLIT;
            end
         end
         S_SPLIT: begin
            wr_en = 1'b1;
            if (j_ff > k_ff) begin
               // hand back the upper half as a free block
               wr_addr = SLOT_W'((best_ff + (OFF_W'(1) << jm)) >> MIN_ORD);
               wr_meta = '{head: 1'b1, used: 1'b0, ord: jm};
               j_in    = jm;
            end else begin
               wr_addr    = SLOT_W'(best_ff >> MIN_ORD);
               wr_meta    = '{head: 1'b1, used: 1'b1, ord: k_ff};
               live_in    = (live_ff != '1) ? live_ff + 1'b1 : live_ff;
               res_off_in = GRANT_W'(best_ff + OFF_W'(HEADER_BYTES));
               state_in   = S_EMIT;
            end
         end
         S_FRD: begin
            state_in = S_FCHK;
         end
         S_FCHK: begin
            if (!rd_meta.head || !rd_meta.used) begin
               res_st_in = ST_BAD_ADDR;
               state_in  = S_EMIT;
            end else begin
               o_in     = rd_meta.ord;
               state_in = S_FLOOP;
            end
         end
         S_FLOOP: begin
            rd_addr  = SLOT_W'(bud >> MIN_ORD);
            state_in = (o_ff < p_ff) ? S_FBCHK : S_FEND;
         end
         S_FBCHK: begin
            if (!rd_meta.head || rd_meta.used || rd_meta.ord != o_ff) begin
               state_in = S_FEND;
            end else begin
               // drop the upper head of the pair, keep the lower one
               wr_en = 1'b1;
               if (bud < off_ff) begin
                  wr_addr = SLOT_W'(off_ff >> MIN_ORD);
                  off_in  = bud;
               end else begin
                  wr_addr = SLOT_W'(bud >> MIN_ORD);
               end
               o_in     = o_ff + 1'b1;
               state_in = S_FLOOP;
            end
         end
         S_FEND: begin
            wr_en    = 1'b1;
            wr_meta  = '{head: 1'b1, used: 1'b0, ord: o_ff};
            live_in  = (live_ff != '0) ? live_ff - 1'b1 : live_ff;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_st_in    = res_st_ff;
               rsp_off_in   = res_off_ff;
               rsp_cnt_in   = res_cnt_ff;
               clr_in       = '0;
               state_in     = clr_after_ff ? S_CLR : S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_ff       <= '0;
         csr_ord_ff   <= POOL_ORDER_RESET;
         ready_ff     <= 1'b0;
         p_ff         <= '0;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         clr_after_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         ready_ff     <= ready_in;
         p_ff         <= p_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
         clr_after_ff <= clr_after_in;
         if (csr_if.valid) begin
            csr_ord_ff <= csr_if.pool_order;
         end
      end
      off_ff      <= off_in;
      best_ff     <= best_in;
      best_ord_ff <= best_ord_in;
      found_ff    <= found_in;
      k_ff        <= k_in;
      j_ff        <= j_in;
      o_ff        <= o_in;
      need_ff     <= need_in;
      res_st_ff   <= res_st_in;
      res_off_ff  <= res_off_in;
      res_cnt_ff  <= res_cnt_in;
      rsp_st_ff   <= rsp_st_in;
      rsp_off_ff  <= rsp_off_in;
      rsp_cnt_ff  <= rsp_cnt_in;
   end
endmodule
`default_nettype wire

@@ design/bba_ram.sv @@
// Generic simple dual-port RAM with registered read.
`default_nettype none
module bba_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

@@ dv/buddy_block_allocator_tb.sv @@
// Self-checking testbench for the buddy block allocator.
`timescale 1ns / 1ps
module buddy_block_allocator_tb;
   import bba_pkg::*;

   localparam int unsigned HDR       = 32;
   localparam int unsigned MIN_ORD   = 5;
   localparam int unsigned MAX_ORD   = 20;
   localparam int unsigned UNITS     = 32768;

   typedef struct {
      status_type       st;
      logic [19:0]      off;
      logic [15:0]      cnt;
   } outcome_type;

   class alloc_scoreboard;
      meta_type              blocks [UNITS];
      logic [15:0]           live;
      bit                    is_ready;
      int unsigned           latched;
      logic [4:0]            pool_order;
      outcome_type           awaiting [$];
      longint unsigned       granted [$];
      int                    mismatches;

      function new();
         wipe();
         is_ready   = 0;
         latched    = 0;
         pool_order = POOL_ORDER_RESET;
         mismatches = 0;
      endfunction

      function void wipe();
         foreach (blocks[i]) blocks[i] = '0;
         live = 0;
         granted.delete();
      endfunction

      function int unsigned unit_of(longint unsigned off);
         return int'((off >> MIN_ORD) & (UNITS - 1));
      endfunction

      function status_type place(longint unsigned req, output longint unsigned got);
         longint unsigned need, off, best, pool;
         int unsigned k, j, best_ord, o;
         meta_type m;
         got = 0;
         need = req + HDR;
         k = 0;
         while (k < 63 && (64'd1 << k) < need) k++;
         if (k < MIN_ORD) k = MIN_ORD;
         if (k > latched) return ST_NO_SPACE;
         pool = 64'd1 << latched;
         off = 0;
         best = 0;
         best_ord = 64;
         while (off < pool) begin
            m = blocks[unit_of(off)];
            o = m.ord;
            if (!m.head || o < MIN_ORD || o > latched) break;
            if (!m.used && o >= k && o < best_ord) begin
               best_ord = o;
               best = off;
            end
            off += 64'd1 << o;
         end
         if (best_ord == 64) return ST_NO_SPACE;
         j = best_ord;
         while (j > k) begin
            j--;
            blocks[unit_of(best + (64'd1 << j))] = '{head: 1'b1, used: 1'b0, ord: j[4:0]};
         end
         blocks[unit_of(best)] = '{head: 1'b1, used: 1'b1, ord: k[4:0]};
         if (live < 16'hFFFF) live++;
         got = best + HDR;
         return ST_OK;
      endfunction

      function status_type release_block(longint unsigned usr);
         longint unsigned off, bud;
         meta_type m, bm;
         int unsigned o;
         if (usr < HDR) return ST_BAD_ADDR;
         off = usr - HDR;
         if (off >= (64'd1 << latched) || off[MIN_ORD-1:0] != 0) return ST_BAD_ADDR;
         m = blocks[unit_of(off)];
         if (!m.head || !m.used) return ST_BAD_ADDR;
         o = m.ord;
         while (o < latched) begin
            bud = off ^ (64'd1 << o);
            bm = blocks[unit_of(bud)];
            if (!bm.head || bm.used || bm.ord != o) break;
            if (bud < off) begin
               blocks[unit_of(off)] = '0;
               off = bud;
            end else begin
               blocks[unit_of(bud)] = '0;
            end
            o++;
         end
         blocks[unit_of(off)] = '{head: 1'b1, used: 1'b0, ord: o[4:0]};
         if (live > 0) live--;
         foreach (granted[i]) if (granted[i] == usr) begin
            granted.delete(i);
            break;
         end
         return ST_OK;
      endfunction

      function void note(op_type op, logic [20:0] req, logic [20:0] usr);
         outcome_type e;
         longint unsigned got;
         int unsigned p;
         e = '{st: ST_OK, off: '0, cnt: '0};
         case (op)
            OP_ALLOC: begin
               if (!is_ready) e.st = ST_NOT_INIT;
               else begin
                  e.st = place(req, got);
                  if (e.st == ST_OK) begin
                     e.off = got[19:0];
                     granted.push_back(got);
                  end
               end
            end
            OP_FREE: begin
               if (!is_ready) e.st = ST_NOT_INIT;
               else e.st = release_block(usr);
            end
            OP_FINISH: begin
               e.cnt = live;
               wipe();
               is_ready = 0;
               latched = 0;
            end
            default: begin
               p = (pool_order > MAX_ORD) ? MAX_ORD : pool_order;
               if (is_ready) e.st = ST_ALREADY;
               else if ((64'd1 << p) < HDR + 1) e.st = ST_NO_SPACE;
               else begin
                  wipe();
                  latched = p;
                  blocks[0] = '{head: 1'b1, used: 1'b0, ord: p[4:0]};
                  is_ready = 1;
               end
            end
         endcase
         awaiting.push_back(e);
      endfunction

      function void check(logic [2:0] st, logic [19:0] off, logic [15:0] cnt);
         outcome_type e;
         if (awaiting.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response: status %0d", st);
            return;
         end
         e = awaiting.pop_front();
         if (st !== e.st || off !== e.off || cnt !== e.cnt) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected st %0d off %0d cnt %0d, got st %0d off %0d cnt %0d",
                        e.st, e.off, e.cnt, st, off, cnt);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   calm;
   bit   rsp_calm;
   int   stall = 0;
   alloc_scoreboard sb;

   bba_req_if rq();
   bba_rsp_if rs();
   bba_csr_if cs();

   buddy_block_allocator dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (rq),
      .rsp_if (rs),
      .csr_if (cs)
   );

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   initial begin
      #40_000_000;
      $display("FAIL");
      $finish;
   end

   function automatic int pick_gap(bit quiet);
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Response side stalls.
   always @(negedge clock) begin
      if (stall > 0) begin
         rs.ready = 1'b0;
         stall--;
      end else begin
         rs.ready = 1'b1;
         stall = pick_gap(rsp_calm);
      end
   end

   always @(posedge clock)
      if (!reset && rs.valid && rs.ready)
         sb.check(rs.status, rs.granted_offset, rs.pending_count);

   task automatic send(op_type op, logic [20:0] req, logic [20:0] usr);
      int gap;
      gap = pick_gap(calm);
      if (gap > 0) begin
         rq.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      rq.op = op;
      rq.request_bytes = req;
      rq.user_offset = usr;
      rq.valid = 1'b1;
      @(posedge clock);
      while (!rq.ready) @(posedge clock);
      sb.note(op, req, usr);
      @(negedge clock);
   endtask

   task automatic drain();
      rq.valid = 1'b0;
      while (sb.awaiting.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_order(logic [4:0] v);
      drain();
      cs.pool_order = v;
      cs.valid = 1'b1;
      @(posedge clock);
      while (!cs.ready) @(posedge clock);
      sb.pool_order = v;
      @(negedge clock);
      cs.valid = 1'b0;
   endtask

   task automatic random_request(int unsigned p);
      int r, k, idx;
      logic [20:0] noise;
      longint unsigned pick;
      r = $urandom_range(0, 99);
      noise = 21'($urandom());
      // Hold live blocks down so the allocation walk stays short.
      if (r < 50 && sb.granted.size() >= 12) r = 60;
      if (r < 50) begin
         k = $urandom_range(0, p);
         if ($urandom_range(0, 19) == 0) send(OP_ALLOC, 21'($urandom()), noise);
         else send(OP_ALLOC, 21'($urandom_range(0, 1 << k)), noise);
      end else if (r < 88 && sb.granted.size() != 0) begin
         idx = $urandom_range(0, sb.granted.size() - 1);
         send(OP_FREE, noise, 21'(sb.granted[idx]));
      end else if (r < 96) begin
         if (sb.granted.size() != 0) begin
            pick = sb.granted[$urandom_range(0, sb.granted.size() - 1)];
            case ($urandom_range(0, 2))
               0: send(OP_FREE, noise, 21'(pick + 1));
               1: send(OP_FREE, noise, 21'(pick + HDR));
               default: send(OP_FREE, noise, 21'($urandom()));
            endcase
         end else send(OP_FREE, noise, 21'($urandom()));
      end else begin
         send(OP_INIT, noise, 21'($urandom()));
      end
   endtask

   initial begin
      int unsigned orders [4];
      sb = new();
      reset = 1'b1;
      calm = 0;
      rsp_calm = 0;
      rq.valid = 1'b0;
      rq.op = OP_ALLOC;
      rq.request_bytes = '0;
      rq.user_offset = '0;
      cs.valid = 1'b0;
      cs.pool_order = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Requests before initialise, then pool size extremes.
      send(OP_ALLOC, 21'd16, 21'd0);
      send(OP_FREE, 21'd0, 21'd32);
      send(OP_FINISH, 21'd0, 21'd0);
      write_order(5'd0);
      send(OP_INIT, 21'd0, 21'd0);
      write_order(5'd5);
      send(OP_INIT, 21'd0, 21'd0);
      write_order(5'd31);
      send(OP_INIT, 21'd0, 21'd0);
      send(OP_INIT, 21'd0, 21'd0);
      send(OP_ALLOC, 21'd1048576, 21'd0);
      send(OP_ALLOC, 21'h1FFFFF, 21'd0);
      send(OP_ALLOC, 21'd1048544, 21'd0);
      send(OP_ALLOC, 21'd0, 21'd0);
      send(OP_FREE, 21'd0, 21'd0);
      send(OP_FREE, 21'd0, 21'd31);
      send(OP_FREE, 21'd0, 21'd33);
      send(OP_FREE, 21'd0, 21'h1FFFFF);
      send(OP_FREE, 21'd0, 21'd1048608);
      send(OP_FREE, 21'd0, 21'd64);
      send(OP_FREE, 21'd0, 21'd32);
      send(OP_FREE, 21'd0, 21'd32);
      send(OP_ALLOC, 21'd0, 21'd0);
      send(OP_ALLOC, 21'd1, 21'd0);
      send(OP_FREE, 21'd0, 21'd32);
      send(OP_FINISH, 21'd0, 21'd0);

      orders = '{6, 9, 13, 20};
      foreach (orders[n]) begin
         write_order(5'(orders[n]));
         send(OP_INIT, 21'($urandom()), 21'($urandom()));
         for (int i = 0; i < 250; i++) begin
            if (i % 50 == 0) begin
               calm = ($urandom_range(0, 3) == 0);
               rsp_calm = ($urandom_range(0, 3) == 0);
            end
            random_request(orders[n]);
         end
         send(OP_FINISH, 21'($urandom()), 21'($urandom()));
      end
      write_order(POOL_ORDER_RESET);

      drain();
      repeat (100) @(posedge clock);
      if (sb.mismatches == 0 && sb.awaiting.size() == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end
endmodule
